// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the page table mapper.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLTM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FLTM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fltm_pkg.sv =====
// Types, widths and codes of the four-level page table mapper.
// No dependencies; used by the interfaces, fltm_walk, the top level and the testbench.
package fltm_pkg;

  localparam int TABLE_COUNT = 64;
  localparam int ENTRIES     = 512;
  localparam int IDX_W       = 9;
  localparam int TIDX_W      = $clog2(TABLE_COUNT);
  localparam int NFT_W       = $clog2(TABLE_COUNT + 1);
  localparam int MEM_DEPTH   = TABLE_COUNT * ENTRIES;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);

  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int OFS_W   = 12;
  localparam int FRAME_W = PA_W - OFS_W;
  localparam int FLAG_W  = 12;
  localparam int ENTRY_W = PA_W;  // stored entries never exceed 52 bits
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 52;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_POOL_BASE    = 2'd0,
    CFG_USER_FLAGS   = 2'd1,
    CFG_KERNEL_FLAGS = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] pool_frame;
    logic [FLAG_W-1:0]  user_flags;
    logic [FLAG_W-1:0]  kernel_flags;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [MEM_AW-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [MEM_AW-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic             clearing;
    logic             alloc;
    logic [NFT_W-1:0] next_free;
  } walk_status_t;

endpackage

// ===== hw/rtl/fltm_chan_if.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on fltm_pkg for field widths.
interface fltm_in_if import fltm_pkg::*;;
  logic            valid;
  logic            ready;
  logic            op;
  logic [VA_W-1:0] virt_addr;
  logic [PA_W-1:0] phys_page;
  logic            user_access;

  modport source (output valid, op, virt_addr, phys_page, user_access, input ready);
  modport sink   (input valid, op, virt_addr, phys_page, user_access, output ready);
endinterface

interface fltm_out_if import fltm_pkg::*;;
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] phys_addr;
  logic            fault;
  logic            out_of_memory;

  modport source (output valid, phys_addr, fault, out_of_memory, input ready);
  modport sink   (input valid, phys_addr, fault, out_of_memory, output ready);
endinterface

// ===== hw/rtl/fltm_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module fltm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fltm_walk.sv =====
// Walk sequencer: clear sweep, table walk, allocation and result register.
// Depends on fltm_pkg and fltm_chan_if; drives the table RAM via mem_req_t.
module fltm_walk import fltm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  fltm_in_if.sink            in_ch,
  fltm_out_if.source         out_ch,
  output mem_req_t           mem_req,
  input  logic [ENTRY_W-1:0] mem_rdata,
  output walk_status_t       status
);

  state_t              state_r, state_nxt;
  logic [MEM_AW-1:0]   clr_addr_r;
  logic [NFT_W-1:0]    nft_r;
  logic [1:0]          level_r;
  logic [TIDX_W-1:0]   table_r;
  op_t                 op_r;
  logic [VA_W-1:0]     va_r;
  logic [PA_W-1:0]     pp_r;
  logic [FLAG_W-1:0]   flags_r;
  logic [PA_W-1:0]     phys_r;
  logic                fault_r;
  logic                oom_r;
  logic                out_valid_r;
  logic [PA_W-1:0]     out_phys_r;
  logic                out_fault_r;
  logic                out_oom_r;

  logic [IDX_W-1:0]    slot_idx;
  logic [MEM_AW-1:0]   slot_addr;
  logic                e_zero;
  logic [FRAME_W-1:0]  rel_frame;
  logic                link_ok;
  logic                pool_full;
  logic [FRAME_W-1:0]  new_frame;
  logic                last_level;
  logic                clr_last;
  logic                out_free;
  logic                do_alloc;
  logic                eval_done;

  // level index out of the virtual address
  always_comb begin
    case (level_r)
      2'd0:    slot_idx = va_r[47:39];
      2'd1:    slot_idx = va_r[38:30];
      2'd2:    slot_idx = va_r[29:21];
      default: slot_idx = va_r[20:12];
    endcase
  end

  assign slot_addr  = {table_r, slot_idx};
  assign e_zero     = (mem_rdata == '0);
  assign rel_frame  = mem_rdata[PA_W-1:OFS_W] - cfg.pool_frame;
  assign link_ok    = rel_frame < FRAME_W'(nft_r);
  assign pool_full  = (nft_r == NFT_W'(TABLE_COUNT));
  assign new_frame  = cfg.pool_frame + FRAME_W'(nft_r);
  assign last_level = (level_r == 2'd3);
  assign clr_last   = (clr_addr_r == MEM_AW'(MEM_DEPTH - 1));
  assign out_free   = !out_valid_r || out_ch.ready;

  // evaluation of the entry just read
  assign do_alloc  = (state_r == ST_EVAL) && (op_r == OP_MAP) && e_zero && !pool_full;
  assign eval_done = (op_r == OP_MAP) ? ((e_zero && pool_full) || (!e_zero && !link_ok))
                                      : (e_zero || last_level || !link_ok);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_READ;
      ST_READ: begin
        if (op_r == OP_MAP && last_level) state_nxt = ST_RESP;
        else state_nxt = ST_EVAL;
      end
      ST_EVAL:  state_nxt = eval_done ? ST_RESP : ST_READ;
      ST_RESP:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs: memory port and input ready
  always_comb begin
    mem_req     = '0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
      end
      ST_IDLE: in_ch.ready = 1'b1;
      ST_READ: begin
        if (op_r == OP_MAP && last_level) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_addr;
          mem_req.wdata = {pp_r[PA_W-1:OFS_W], pp_r[OFS_W-1:0] | flags_r};
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot_addr;
        end
      end
      ST_EVAL: begin
        if (do_alloc) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot_addr;
          mem_req.wdata = {new_frame, flags_r};
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      nft_r       <= NFT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (do_alloc) nft_r <= nft_r + 1'b1;
      if (state_r == ST_RESP && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      op_r    <= op_t'(in_ch.op);
      va_r    <= in_ch.virt_addr;
      pp_r    <= in_ch.phys_page;
      flags_r <= in_ch.user_access ? cfg.user_flags : cfg.kernel_flags;
      level_r <= 2'd0;
      table_r <= '0;
      phys_r  <= '0;
      fault_r <= 1'b0;
      oom_r   <= 1'b0;
    end
    if (state_r == ST_EVAL) begin
      if (op_r == OP_MAP) begin
        if (e_zero) begin
          if (pool_full) oom_r <= 1'b1;
          else table_r <= nft_r[TIDX_W-1:0];
        end else if (!link_ok) fault_r <= 1'b1;
        else table_r <= rel_frame[TIDX_W-1:0];
      end else begin
        if (e_zero) fault_r <= 1'b1;
        else if (last_level) phys_r <= {mem_rdata[PA_W-1:OFS_W], va_r[OFS_W-1:0]};
        else if (!link_ok) fault_r <= 1'b1;
        else table_r <= rel_frame[TIDX_W-1:0];
      end
      if (!eval_done) level_r <= level_r + 1'b1;
    end
    if (state_r == ST_RESP && out_free) begin
      out_phys_r  <= phys_r;
      out_fault_r <= fault_r;
      out_oom_r   <= oom_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.phys_addr     = out_phys_r;
  assign out_ch.fault         = out_fault_r;
  assign out_ch.out_of_memory = out_oom_r;

  assign status.clearing  = (state_r == ST_CLEAR);
  assign status.alloc     = do_alloc;
  assign status.next_free = nft_r;

endmodule

// ===== hw/rtl/four_level_page_table_mapper.sv =====
// Four-level page table mapper: top level with config registers and table RAM.
// Depends on fltm_pkg, fltm_chan_if, fltm_ram, fltm_walk and assert_macros.svh.
//
// Usage:
//  - in_ch carries one request word: op (map or translate), virt_addr, phys_page and
//    user_access. out_ch returns exactly one result word per request: phys_addr,
//    fault and out_of_memory. Both use valid/ready; a word moves when both are high.
//  - cfg_we/cfg_index/cfg_data write pool_base, user_flags or kernel_flags; other
//    indexes are dropped. Write only while no request is in flight.
//  - Tables live in one RAM of TABLE_COUNT*512 entries with registered read data.
//    Each level costs a read state and an evaluate state (an allocation writes the
//    new link in the evaluate state); a map's leaf write takes the last level's read
//    state, and every request ends in a response state that loads the result
//    register. The next request is taken in the idle state after the load, so the
//    block works on one request at a time.
//  - Reset: a clearing sweep zeroes all TABLE_COUNT*512 RAM entries (32768 at the
//    default pool size), one entry per cycle. in_ch.ready stays low until it ends;
//    config writes are taken throughout.
//  - Result register: the next request is accepted while a result word waits.
//    If out_ch stalls, the walker holds its finished result until the register frees.
module four_level_page_table_mapper import fltm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fltm_in_if.sink           in_ch,
  fltm_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

`include "assert_macros.svh"

  cfg_t               cfg_r;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  walk_status_t       status;
  logic               nft_ok;
  logic               oom_word;
  logic               oom_clean;
  logic [NFT_W-1:0]   nft_inc;

  // config registers; pool_base keeps only its frame bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_frame   <= '0;
      cfg_r.user_flags   <= FLAG_W'(7);
      cfg_r.kernel_flags <= FLAG_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:    cfg_r.pool_frame   <= cfg_data[PA_W-1:OFS_W];
        CFG_USER_FLAGS:   cfg_r.user_flags   <= cfg_data[FLAG_W-1:0];
        CFG_KERNEL_FLAGS: cfg_r.kernel_flags <= cfg_data[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  // table store
  fltm_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // walk sequencer and result register
  fltm_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .status    (status)
  );

  // checker terms
  assign nft_ok    = (status.next_free != '0) && (status.next_free <= NFT_W'(TABLE_COUNT));
  assign oom_word  = out_ch.valid && out_ch.out_of_memory;
  assign oom_clean = !out_ch.fault && (out_ch.phys_addr == '0);
  assign nft_inc   = status.next_free + 1'b1;

  `FLTM_ASSERT(a_no_accept_clear, status.clearing, !in_ch.ready, "request accepted during clear")
  `FLTM_ASSERT(a_nft_range, 1'b1, nft_ok, "next free table out of range")
  `FLTM_ASSERT(a_oom_clean, oom_word, oom_clean, "out of memory word carries fault or address")
  `FLTM_ASSERT_NXT(a_alloc_step, status.alloc, status.next_free == $past(nft_inc), "bad nft step")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for four_level_page_table_mapper: directed words, then random phases.
// Depends on fltm_pkg, the fltm_in_if/fltm_out_if interfaces and the mapper RTL.
module tb import fltm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     HALF_PERIOD = 5;
  localparam int     RESET_CYCLES = 9;
  localparam int     DRAIN_SLACK = 16;    // idle margin after the last result
  localparam int     END_WAIT_MAX = 5000;
  localparam int     PHASE_COUNT = 6;
  localparam int     PHASE_ITEMS = 292;
  localparam int     LONG_HOLD = 400;
  localparam int     DIRECTED_ROWS = 25;
  localparam longint TIMEOUT_NS = 64'd6_000_000;  // clear sweep plus many worst-case walks
  localparam logic [CFG_IW-1:0] CFG_SPARE_IDX = 2'd3;  // no register behind this index
  localparam logic [VA_W-1:0]   INDEX_MASK = 48'h1FF;
  localparam int     MAPPED_KEEP = 64;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic            fault;
    logic            out_of_memory;
  } result_t;

  // One stimulus row: either a register write or a request word.
  typedef struct packed {
    logic              is_cfg;
    logic [CFG_IW-1:0] ridx;
    logic [CFG_DW-1:0] rval;
    op_t               op;
    logic [VA_W-1:0]   va;
    logic [PA_W-1:0]   pp;
    logic              ua;
    logic              known;  // want holds a hand-written result
    result_t           want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  fltm_in_if  in_ch ();
  fltm_out_if out_ch ();

  four_level_page_table_mapper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the table pool and registers
  // ---------------------------------------------------------------------
  bit   [PA_W-1:0]   table_mem [MEM_DEPTH];  // zero, like the RAM after its clear sweep
  int unsigned       next_table = 1;         // root is table zero
  logic [PA_W-1:0]   base_m = '0;
  logic [FLAG_W-1:0] user_m = 12'd7;
  logic [FLAG_W-1:0] kernel_m = 12'd3;

  result_t         expected_results [$];
  logic [VA_W-1:0] mapped_vas [$];  // recent successful maps, reused by translates

  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int hold_cycles = 0;

  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_faults = 0;
  int n_oom = 0;
  int n_writes = 0;

  // Table index named by a link, or -1 when the link points outside the
  // allocated part of the pool as seen from the current base.
  function automatic int link_target(logic [PA_W-1:0] ent);
    logic [PA_W-1:0] rel;
    rel = {ent[PA_W-1:OFS_W], {OFS_W{1'b0}}} - base_m;
    if (rel[PA_W-1:OFS_W] >= FRAME_W'(next_table)) return -1;
    return int'(rel[PA_W-1:OFS_W]);
  endfunction

  // Walk the shadow tables for one request word; a map updates them.
  function automatic result_t walk_tables(op_t op, logic [VA_W-1:0] va,
                                          logic [PA_W-1:0] pp, logic ua);
    result_t           r;
    logic [FLAG_W-1:0] fl;
    logic [PA_W-1:0]   ent;
    int unsigned       tbl;
    int unsigned       slot;
    int                nxt;
    int                lvl;
    bit                stop;
    r = '0;
    fl = ua ? user_m : kernel_m;
    tbl = 0;
    stop = 1'b0;
    for (lvl = 0; lvl < 4 && !stop; lvl++) begin
      slot = tbl * ENTRIES + int'((va >> (39 - 9 * lvl)) & INDEX_MASK);
      ent = table_mem[slot];
      if (op == OP_MAP) begin
        if (lvl == 3) begin
          table_mem[slot] = pp | PA_W'(fl);
        end else if (ent == '0) begin
          if (next_table >= TABLE_COUNT) begin
            // pool exhausted: earlier links of this word stay, no leaf
            r.out_of_memory = 1'b1;
            stop = 1'b1;
          end else begin
            tbl = next_table;
            next_table++;
            // may wrap to zero, which later walks read as empty
            table_mem[slot] = (base_m + (PA_W'(tbl) << OFS_W)) | PA_W'(fl);
          end
        end else begin
          nxt = link_target(ent);
          if (nxt < 0) begin
            r.fault = 1'b1;
            stop = 1'b1;
          end else begin
            tbl = nxt;
          end
        end
      end else begin
        if (ent == '0) begin
          r.fault = 1'b1;  // empty link, or a zero leaf
          stop = 1'b1;
        end else if (lvl < 3) begin
          nxt = link_target(ent);
          if (nxt < 0) begin
            r.fault = 1'b1;
            stop = 1'b1;
          end else begin
            tbl = nxt;
          end
        end else begin
          r.phys_addr = {ent[PA_W-1:OFS_W], {OFS_W{1'b0}}} + PA_W'(va[OFS_W-1:0]);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus rows
  // ---------------------------------------------------------------------
  function automatic row_t stim_row(op_t op, logic [VA_W-1:0] va, logic [PA_W-1:0] pp,
                                    logic ua);
    row_t w;
    w = '0;
    w.op = op;
    w.va = va;
    w.pp = pp;
    w.ua = ua;
    return w;
  endfunction

  function automatic row_t known_row(op_t op, logic [VA_W-1:0] va, logic [PA_W-1:0] pp,
                                     logic ua, logic fault);
    row_t w;
    w = stim_row(op, va, pp, ua);
    w.known = 1'b1;
    w.want.fault = fault;  // phys_addr and out_of_memory stay zero
    return w;
  endfunction

  function automatic row_t cfg_row(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    row_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.ridx = idx;
    w.rval = val;
    return w;
  endfunction

  // Mostly a few shared indices, so walks meet existing tables.
  function automatic logic [8:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return 9'($urandom);
      1, 2:    return 9'd0;
      3, 4:    return 9'd1;
      default: return 9'd511;
    endcase
  endfunction

  function automatic row_t rand_item();
    row_t            w;
    int unsigned     r;
    logic [VA_W-1:0] va;
    logic [PA_W-1:0] pp;
    r = $urandom_range(0, 99);
    va = {pick_index(), pick_index(), pick_index(), 9'($urandom), 12'($urandom)};
    pp = PA_W'({$urandom, $urandom});
    if (r % 4 != 0) pp[OFS_W-1:0] = '0;  // page aligned most of the time
    w = stim_row(OP_MAP, va, pp, 1'($urandom));
    if (r >= 85) begin
      // noise over the whole field range
      w.op = op_t'($urandom_range(0, 1));
      w.va = VA_W'({$urandom, $urandom});
      w.pp = PA_W'({$urandom, $urandom});
    end else if (r >= 45) begin
      w.op = OP_XLATE;
      if (mapped_vas.size() != 0 && $urandom_range(0, 3) != 0) begin
        va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
        w.va = {va[VA_W-1:OFS_W], 12'($urandom)};
      end
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  // Offer one request word; valid stays high after the handshake so that
  // back-to-back words need no extra edge.
  task automatic send_word(input row_t w);
    result_t pred;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= w.op;
    in_ch.virt_addr   <= w.va;
    in_ch.phys_page   <= w.pp;
    in_ch.user_access <= w.ua;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = walk_tables(w.op, w.va, w.pp, w.ua);
    expected_results.push_back(w.known ? w.want : pred);
    if (w.op == OP_MAP && !pred.fault && !pred.out_of_memory) begin
      mapped_vas.push_back(w.va);
      if (mapped_vas.size() > MAPPED_KEEP) void'(mapped_vas.pop_front());
    end
    n_items++;
  endtask

  // Stop offering and let every outstanding walk finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POOL_BASE:    base_m = {val[PA_W-1:OFS_W], {OFS_W{1'b0}}};
      CFG_USER_FLAGS:   user_m = val[FLAG_W-1:0];
      CFG_KERNEL_FLAGS: kernel_m = val[FLAG_W-1:0];
      default: ;  // spare index is dropped
    endcase
    n_writes++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: ready with random stalls, plus one long hold-off that
  // backs the walker up until in_ch.ready drops.
  // ---------------------------------------------------------------------
  initial begin
    int n;
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (out_ch.fault === 1'b1) n_faults++;
      if (out_ch.out_of_memory === 1'b1) n_oom++;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: phys_addr %h", $time,
                 out_ch.phys_addr);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.phys_addr !== exp_r.phys_addr) begin
          $display("%0t: phys_addr expected %h actual %h", $time, exp_r.phys_addr,
                   out_ch.phys_addr);
          mismatches++;
        end
        if (out_ch.fault !== exp_r.fault) begin
          $display("%0t: fault expected %b actual %b", $time, exp_r.fault, out_ch.fault);
          mismatches++;
        end
        if (out_ch.out_of_memory !== exp_r.out_of_memory) begin
          $display("%0t: out_of_memory expected %b actual %b", $time, exp_r.out_of_memory,
                   out_ch.out_of_memory);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  row_t directed [DIRECTED_ROWS];

  initial begin
    int ph;
    int wait_n;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_POOL_BASE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_MAP;
    in_ch.virt_addr   <= '0;
    in_ch.phys_page   <= '0;
    in_ch.user_access <= 1'b0;

    // Reset values first, then the corner cases. Tables are handed out in
    // order: the first map takes 1..3, the second 4..6, the 8000_0000_0000
    // map 7..9, so the pool base below wraps table 10 to address zero.
    directed = '{
      known_row(OP_XLATE, 48'h0,               52'h0, 1'b0, 1'b1),  // empty root
      known_row(OP_XLATE, 48'hFFFF_FFFF_FFFF,  52'h0, 1'b1, 1'b1),
      known_row(OP_MAP,   48'h0,               52'h0, 1'b0, 1'b0),
      stim_row (OP_XLATE, 48'h0000_0000_0FFF,  52'h0, 1'b0),
      known_row(OP_MAP,   48'hFFFF_FFFF_FFFF,  52'hF_FFFF_FFFF_F000, 1'b1, 1'b0),
      stim_row (OP_XLATE, 48'hFFFF_FFFF_FFFF,  52'hF_FFFF_FFFF_FFFF, 1'b0),
      known_row(OP_XLATE, 48'h0000_0000_1000,  52'h0, 1'b0, 1'b1),  // leaf never written
      known_row(OP_MAP,   48'h0000_0000_1000,  52'h5_5555_5555_5000, 1'b1, 1'b0),
      stim_row (OP_XLATE, 48'h0000_0000_1ABC,  52'h0, 1'b1),
      cfg_row  (CFG_KERNEL_FLAGS, 52'h0),
      known_row(OP_MAP,   48'h0000_0000_2000,  52'h0, 1'b0, 1'b0),  // zero leaf
      known_row(OP_XLATE, 48'h0000_0000_2000,  52'h0, 1'b0, 1'b1),
      cfg_row  (CFG_SPARE_IDX, 52'hF_FFFF_FFFF_FFFF),
      stim_row (OP_XLATE, 48'h0000_0000_1ABC,  52'h0, 1'b0),
      cfg_row  (CFG_USER_FLAGS, 52'hF_FFFF_FFFF_FFFF),
      known_row(OP_MAP,   48'h8000_0000_0000,  52'hA_AAAA_AAAA_AFFF, 1'b1, 1'b0),
      stim_row (OP_XLATE, 48'h8000_0000_0123,  52'h0, 1'b1),
      cfg_row  (CFG_POOL_BASE, 52'hF_FFFF_FFFF_6ABC),
      stim_row (OP_MAP,   48'h4000_0000_0000,  52'h1_2345_6789_A000, 1'b0),  // zero link
      stim_row (OP_XLATE, 48'h4000_0000_0000,  52'h0, 1'b0),
      stim_row (OP_XLATE, 48'h8000_0000_0123,  52'h0, 1'b1),  // old link off the pool
      stim_row (OP_MAP,   48'h8000_0000_5000,  52'h0, 1'b1),
      cfg_row  (CFG_POOL_BASE, 52'h0),
      cfg_row  (CFG_KERNEL_FLAGS, 52'h3),
      cfg_row  (CFG_USER_FLAGS, 52'h7)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // in_ch.ready stays low through the clear sweep; send_word just waits

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_reg(directed[i].ridx, directed[i].rval);
      end else begin
        send_word(directed[i]);
      end
    end

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_POOL_BASE, 52'h0);
          write_reg(CFG_USER_FLAGS, 52'h7);
          write_reg(CFG_KERNEL_FLAGS, 52'h3);
        end
        1: begin
          write_reg(CFG_USER_FLAGS, CFG_DW'($urandom));
          write_reg(CFG_KERNEL_FLAGS, CFG_DW'($urandom));
          hold_cycles = LONG_HOLD;
        end
        2: begin
          // random base: nearly every old link now falls outside the pool
          write_reg(CFG_POOL_BASE, CFG_DW'({$urandom, $urandom}));
          write_reg(CFG_USER_FLAGS, 52'h0);
          write_reg(CFG_KERNEL_FLAGS, 52'hFFF);
        end
        3: begin
          write_reg(CFG_POOL_BASE, 52'h0);
          write_reg(CFG_USER_FLAGS, 52'h0);
          write_reg(CFG_KERNEL_FLAGS, 52'h0);
        end
        4: begin
          write_reg(CFG_POOL_BASE, 52'hF_FFFF_FFFF_FFFF);
          write_reg(CFG_USER_FLAGS, 52'hFFF);
          write_reg(CFG_KERNEL_FLAGS, 52'hFFF);
          write_reg(CFG_SPARE_IDX, CFG_DW'({$urandom, $urandom}));
        end
        default: begin
          write_reg(CFG_POOL_BASE, 52'h0);
          write_reg(CFG_USER_FLAGS, 52'h7);
          write_reg(CFG_KERNEL_FLAGS, 52'h3);
          // closing stretch runs at full rate on both sides
          tx_gaps = 1'b0;
          rx_stalls = 1'b0;
        end
      endcase
      repeat (PHASE_ITEMS) send_word(rand_item());
    end

    in_ch.valid <= 1'b0;
    for (wait_n = 0; wait_n < END_WAIT_MAX && expected_results.size() != 0; wait_n++)
      @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time,
               expected_results.size());
      mismatches += expected_results.size();
    end

    $display("Run covered %0d request words (%0d directed rows) and %0d register writes",
             n_items, DIRECTED_ROWS, n_writes);
    $display("over %0d phases; %0d results checked, %0d faults, %0d out of memory",
             PHASE_COUNT, n_results, n_faults, n_oom);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fltm_pkg.sv
hw/rtl/fltm_chan_if.sv
hw/rtl/fltm_ram.sv
hw/rtl/fltm_walk.sv
hw/rtl/four_level_page_table_mapper.sv
dv/tb.sv
